// File: rtl/core/zcd_pkg.sv
// ============================================================================
// zcd_pkg
// Shared types and constants of the central directory record parser.
// ============================================================================
package zcd_pkg;

    localparam logic [31:0] HDR_SIG      = 32'h02014b50;
    localparam logic [31:0] ALL_ONES32   = 32'hffffffff;
    localparam logic [15:0] ZIP64_TAG    = 16'h0001;

    // byte offsets inside the 46-byte fixed header
    localparam logic [15:0] OFS_SIG_LAST    = 16'd3;
    localparam logic [15:0] OFS_CSIZE       = 16'd20;
    localparam logic [15:0] OFS_USIZE       = 16'd24;
    localparam logic [15:0] OFS_NAME_LEN    = 16'd28;
    localparam logic [15:0] OFS_EXTRA_LEN   = 16'd30;
    localparam logic [15:0] OFS_COMMENT_LEN = 16'd32;
    localparam logic [15:0] OFS_HDR_LAST    = 16'd45;

    localparam int FIFO_DEPTH = 4;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_NAME,
        PH_EXTRA,
        PH_COMMENT
    } t_phase;

    typedef enum logic [1:0] {
        KIND_NAME  = 2'd0,
        KIND_ENTRY = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_HEADER = 2'd1,
        ST_TRUNCATED  = 2'd2
    } t_status;

    // What one input byte produced: an optional name byte, then an optional
    // entry-complete or error result.
    typedef struct packed {
        logic        has_name;
        logic [7:0]  name_byte;
        logic        has_tail;
        t_kind       tail_kind;
        logic [63:0] csize;
        logic [63:0] usize;
        logic [15:0] name_length;
        logic [31:0] entry;
        logic        bump;
        t_status     status;
        logic        fin;
    } t_evt;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  name_byte;
        logic [63:0] compressed_size;
        logic [63:0] uncompressed_size;
        logic [15:0] name_length;
        logic [31:0] entry_number;
        t_status     status;
        logic        final_res;
    } t_res;

endpackage

// File: rtl/core/zcd_if.sv
// ============================================================================
// zcd_if
// Valid/ready channels of the parser: byte stream in, results out.
// ============================================================================
interface zcd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_data;

    modport source (output valid, data_byte, end_of_data, input ready);
    modport sink   (input valid, data_byte, end_of_data, output ready);
endinterface

interface zcd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  name_byte;
    logic [63:0] compressed_size;
    logic [63:0] uncompressed_size;
    logic [15:0] name_length;
    logic [31:0] entry_number;
    logic [1:0]  status;
    logic        final_res;

    modport source (output valid, kind, name_byte, compressed_size, uncompressed_size,
                    name_length, entry_number, status, final_res, input ready);
    modport sink   (input valid, kind, name_byte, compressed_size, uncompressed_size,
                    name_length, entry_number, status, final_res, output ready);
endinterface

// File: rtl/core/zcd_front.sv
// ============================================================================
// zcd_front
// Record parser: takes one byte per item, tracks header/name/extra/comment
// phases, scans the extra field for ZIP64 sizes and emits result events.
// ============================================================================
module zcd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    zcd_in_if.sink        i_in,
    input  logic          i_cfg_we,
    input  logic [31:0]   i_cfg_data,
    input  logic          i_full,
    output logic          o_push,
    output zcd_pkg::t_evt o_evt
);

    // control
    zcd_pkg::t_phase r_phase, n_phase;
    logic [15:0]     r_pos, n_pos;
    logic [31:0]     r_entries, n_entries;
    logic            r_halted, n_halted;
    logic [31:0]     r_entry_count;

    // captured header fields and extra scan
    logic [23:0] r_sig, n_sig;
    logic [31:0] r_small_c, n_small_c;
    logic [31:0] r_small_u, n_small_u;
    logic [15:0] r_name_len, n_name_len;
    logic [15:0] r_extra_len, n_extra_len;
    logic [15:0] r_comment_len, n_comment_len;
    logic [63:0] r_big_c, n_big_c;
    logic [63:0] r_big_u, n_big_u;
    logic [15:0] r_tag_id, n_tag_id;
    logic [15:0] r_tag_len, n_tag_len;
    logic [15:0] r_tag_off, n_tag_off;
    logic        r_scan_done, n_scan_done;

    logic            w_acc, w_active, w_end, w_sig_bad, w_complete, w_last;
    logic [16:0]     w_pos1;
    zcd_pkg::t_phase w_adv;
    zcd_pkg::t_evt   w_evt;
    logic [7:0]      w_b;

    assign i_in.ready = !i_full;
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_active   = w_acc && !r_halted && (r_entries < r_entry_count);
    assign w_b        = i_in.data_byte;
    assign w_pos1     = {1'b0, r_pos} + 17'd1;
    assign w_last     = (r_entries + 32'd1) == r_entry_count;
    assign w_sig_bad  = (r_phase == zcd_pkg::PH_HEADER) && (r_pos == zcd_pkg::OFS_SIG_LAST)
                        && ({w_b, r_sig} != zcd_pkg::HDR_SIG);

    // last byte of the current phase
    always_comb begin
        unique case (r_phase)
            zcd_pkg::PH_HEADER:  w_end = (r_pos == zcd_pkg::OFS_HDR_LAST);
            zcd_pkg::PH_NAME:    w_end = (w_pos1 >= {1'b0, r_name_len});
            zcd_pkg::PH_EXTRA:   w_end = (w_pos1 >= {1'b0, r_extra_len});
            zcd_pkg::PH_COMMENT: w_end = (w_pos1 >= {1'b0, r_comment_len});
        endcase
    end

    // phase that follows, skipping empty sections
    always_comb begin
        unique case (r_phase)
            zcd_pkg::PH_HEADER: begin
                if (r_name_len != 16'd0)         w_adv = zcd_pkg::PH_NAME;
                else if (r_extra_len != 16'd0)   w_adv = zcd_pkg::PH_EXTRA;
                else if (r_comment_len != 16'd0) w_adv = zcd_pkg::PH_COMMENT;
                else                             w_adv = zcd_pkg::PH_HEADER;
            end
            zcd_pkg::PH_NAME: begin
                if (r_extra_len != 16'd0)        w_adv = zcd_pkg::PH_EXTRA;
                else if (r_comment_len != 16'd0) w_adv = zcd_pkg::PH_COMMENT;
                else                             w_adv = zcd_pkg::PH_HEADER;
            end
            zcd_pkg::PH_EXTRA: begin
                if (r_comment_len != 16'd0)      w_adv = zcd_pkg::PH_COMMENT;
                else                             w_adv = zcd_pkg::PH_HEADER;
            end
            zcd_pkg::PH_COMMENT: w_adv = zcd_pkg::PH_HEADER;
        endcase
    end

    assign w_complete = w_end && (w_adv == zcd_pkg::PH_HEADER) && !w_sig_bad;

    // next state
    always_comb begin
        n_phase = r_phase;
        if (w_active && !w_sig_bad && w_end) begin
            n_phase = w_adv;
        end
    end

    // datapath and events
    always_comb begin
        logic [15:0] remain;
        logic [15:0] full_len;
        logic [15:0] d;
        logic [15:0] cz;
        logic        usub;
        logic        csub;

        remain   = r_extra_len - r_pos - 16'd1;
        full_len = {w_b, r_tag_len[7:0]};
        d        = r_tag_off - 16'd4;
        usub     = (r_small_u == zcd_pkg::ALL_ONES32) && (r_tag_len >= 16'd8);
        cz       = usub ? 16'd8 : 16'd0;
        csub     = (r_small_c == zcd_pkg::ALL_ONES32) && (r_tag_len >= cz + 16'd8);

        n_pos         = r_pos;
        n_entries     = r_entries;
        n_halted      = r_halted;
        n_sig         = r_sig;
        n_small_c     = r_small_c;
        n_small_u     = r_small_u;
        n_name_len    = r_name_len;
        n_extra_len   = r_extra_len;
        n_comment_len = r_comment_len;
        n_big_c       = r_big_c;
        n_big_u       = r_big_u;
        n_tag_id      = r_tag_id;
        n_tag_len     = r_tag_len;
        n_tag_off     = r_tag_off;
        n_scan_done   = r_scan_done;
        w_evt         = '0;

        if (w_active) begin
            if (r_phase == zcd_pkg::PH_HEADER) begin
                n_sig = {w_b, r_sig[23:8]};
                if (r_pos >= zcd_pkg::OFS_CSIZE && r_pos < zcd_pkg::OFS_USIZE) begin
                    if (r_pos == zcd_pkg::OFS_CSIZE) n_small_c = {24'd0, w_b};
                    else n_small_c[{r_pos[1:0], 3'b000} +: 8] = w_b;
                end
                if (r_pos >= zcd_pkg::OFS_USIZE && r_pos < zcd_pkg::OFS_NAME_LEN) begin
                    if (r_pos == zcd_pkg::OFS_USIZE) n_small_u = {24'd0, w_b};
                    else n_small_u[{r_pos[1:0], 3'b000} +: 8] = w_b;
                end
                if (r_pos == zcd_pkg::OFS_NAME_LEN)           n_name_len = {8'd0, w_b};
                if (r_pos == zcd_pkg::OFS_NAME_LEN + 16'd1)   n_name_len[15:8] = w_b;
                if (r_pos == zcd_pkg::OFS_EXTRA_LEN)          n_extra_len = {8'd0, w_b};
                if (r_pos == zcd_pkg::OFS_EXTRA_LEN + 16'd1)  n_extra_len[15:8] = w_b;
                if (r_pos == zcd_pkg::OFS_COMMENT_LEN)        n_comment_len = {8'd0, w_b};
                if (r_pos == zcd_pkg::OFS_COMMENT_LEN + 16'd1) n_comment_len[15:8] = w_b;
                if (w_end) begin
                    n_big_c = {32'd0, r_small_c};
                    n_big_u = {32'd0, r_small_u};
                end
            end

            if (r_phase == zcd_pkg::PH_EXTRA) begin
                if (!r_scan_done) begin
                    if (r_tag_off < 16'd4) begin
                        case (r_tag_off[1:0])
                            2'd0:    n_tag_id = {8'd0, w_b};
                            2'd1:    n_tag_id[15:8] = w_b;
                            2'd2:    n_tag_len = {8'd0, w_b};
                            default: n_tag_len[15:8] = w_b;
                        endcase
                        if (r_tag_off != 16'd3) begin
                            n_tag_off = r_tag_off + 16'd1;
                        end else if (full_len > remain) begin
                            // item overruns the extra field: stop scanning
                            n_scan_done = 1'b1;
                            n_tag_id    = 16'd0;
                        end else if (r_tag_id == zcd_pkg::ZIP64_TAG) begin
                            n_scan_done = 1'b1;
                            n_tag_off   = 16'd4;
                        end else begin
                            n_tag_off = (full_len == 16'd0) ? 16'd0 : 16'd4;
                        end
                    end else if ((r_tag_off - 16'd3) >= r_tag_len) begin
                        n_tag_off = 16'd0;
                    end else begin
                        n_tag_off = r_tag_off + 16'd1;
                    end
                end else if (r_tag_id == zcd_pkg::ZIP64_TAG && r_tag_off >= 16'd4) begin
                    if (usub && d < 16'd8) begin
                        if (d == 16'd0) n_big_u = {56'd0, w_b};
                        else n_big_u[{d[2:0], 3'b000} +: 8] = w_b;
                    end
                    if (csub && d >= cz && d < cz + 16'd8) begin
                        if (d == cz) n_big_c = {56'd0, w_b};
                        else n_big_c[{d[2:0], 3'b000} +: 8] = w_b;
                    end
                    if (d + 16'd1 < r_tag_len) n_tag_off = r_tag_off + 16'd1;
                end
            end

            n_pos = w_end ? 16'd0 : r_pos + 16'd1;
            if (w_end && w_adv == zcd_pkg::PH_EXTRA && !w_sig_bad) begin
                n_tag_id    = 16'd0;
                n_tag_len   = 16'd0;
                n_tag_off   = 16'd0;
                n_scan_done = 1'b0;
            end

            w_evt.entry       = r_entries;
            w_evt.name_length = r_name_len;
            if (r_phase == zcd_pkg::PH_NAME) begin
                w_evt.has_name  = 1'b1;
                w_evt.name_byte = w_b;
            end

            if (w_sig_bad) begin
                w_evt.has_tail  = 1'b1;
                w_evt.tail_kind = zcd_pkg::KIND_ERROR;
                w_evt.status    = zcd_pkg::ST_BAD_HEADER;
                w_evt.fin       = 1'b1;
                n_halted        = 1'b1;
            end else if (w_complete) begin
                n_entries      = r_entries + 32'd1;
                w_evt.has_tail = 1'b1;
                if (i_in.end_of_data && !w_last) begin
                    // record done but the next header is missing
                    w_evt.tail_kind = zcd_pkg::KIND_ERROR;
                    w_evt.status    = zcd_pkg::ST_BAD_HEADER;
                    w_evt.bump      = 1'b1;
                    w_evt.fin       = 1'b1;
                    n_halted        = 1'b1;
                end else begin
                    w_evt.tail_kind = zcd_pkg::KIND_ENTRY;
                    w_evt.csize     = n_big_c;
                    w_evt.usize     = n_big_u;
                    w_evt.fin       = w_last;
                end
            end else if (i_in.end_of_data) begin
                w_evt.has_tail  = 1'b1;
                w_evt.tail_kind = zcd_pkg::KIND_ERROR;
                w_evt.status    = (n_phase == zcd_pkg::PH_HEADER) ? zcd_pkg::ST_BAD_HEADER
                                                                  : zcd_pkg::ST_TRUNCATED;
                w_evt.fin       = 1'b1;
                n_halted        = 1'b1;
            end
        end
    end

    assign o_push = w_active && (w_evt.has_name || w_evt.has_tail);
    assign o_evt  = w_evt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= zcd_pkg::PH_HEADER;
            r_pos         <= 16'd0;
            r_entries     <= 32'd0;
            r_halted      <= 1'b0;
            r_entry_count <= 32'd0;
        end else begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_entries <= n_entries;
            r_halted  <= n_halted;
            if (i_cfg_we) begin
                r_entry_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sig         <= n_sig;
        r_small_c     <= n_small_c;
        r_small_u     <= n_small_u;
        r_name_len    <= n_name_len;
        r_extra_len   <= n_extra_len;
        r_comment_len <= n_comment_len;
        r_big_c       <= n_big_c;
        r_big_u       <= n_big_u;
        r_tag_id      <= n_tag_id;
        r_tag_len     <= n_tag_len;
        r_tag_off     <= n_tag_off;
        r_scan_done   <= n_scan_done;
    end

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("halt flag dropped without reset");

    a_no_push_halted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |-> !o_push)
        else $error("event pushed after halt");

endmodule

// File: rtl/core/zcd_fifo.sv
// ============================================================================
// zcd_fifo
// Short event queue between parser and result sequencer.
// ============================================================================
module zcd_fifo #(
    parameter int DEPTH = zcd_pkg::FIFO_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  zcd_pkg::t_evt i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output zcd_pkg::t_evt o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    zcd_pkg::t_evt r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: rtl/core/zcd_back.sv
// ============================================================================
// zcd_back
// Result sequencer: splits each event into one or two result items and
// drives them through the output register.
// ============================================================================
module zcd_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  zcd_pkg::t_evt i_head,
    output logic          o_pop,
    zcd_out_if.source     o_out
);

    zcd_pkg::t_res r_out, n_out;
    logic          r_out_valid, n_out_valid;
    zcd_pkg::t_evt r_cur, n_cur;
    logic          r_pend, n_pend;
    logic          w_out_free;

    function automatic zcd_pkg::t_res f_name(input zcd_pkg::t_evt e);
        zcd_pkg::t_res r;
        r              = '0;
        r.kind         = zcd_pkg::KIND_NAME;
        r.name_byte    = e.name_byte;
        r.name_length  = e.name_length;
        r.entry_number = e.entry;
        r.status       = zcd_pkg::ST_OK;
        return r;
    endfunction

    function automatic zcd_pkg::t_res f_tail(input zcd_pkg::t_evt e);
        zcd_pkg::t_res r;
        r                   = '0;
        r.kind              = e.tail_kind;
        r.compressed_size   = e.csize;
        r.uncompressed_size = e.usize;
        r.name_length       = (e.tail_kind == zcd_pkg::KIND_ENTRY) ? e.name_length : 16'd0;
        r.entry_number      = e.entry + {31'd0, e.bump};
        r.status            = e.status;
        r.final_res         = e.fin;
        return r;
    endfunction

    assign w_out_free = !r_out_valid || o_out.ready;
    assign o_pop      = !r_pend && !i_empty && w_out_free;

    always_comb begin
        n_out       = r_out;
        n_out_valid = r_out_valid;
        n_cur       = r_cur;
        n_pend      = r_pend;
        if (w_out_free) begin
            n_out_valid = 1'b0;
            if (r_pend) begin
                n_out       = f_tail(r_cur);
                n_out_valid = 1'b1;
                n_pend      = 1'b0;
            end else if (!i_empty) begin
                n_out       = i_head.has_name ? f_name(i_head) : f_tail(i_head);
                n_out_valid = 1'b1;
                if (i_head.has_name && i_head.has_tail) begin
                    n_pend = 1'b1;
                    n_cur  = i_head;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        r_cur <= n_cur;
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.kind              = r_out.kind;
    assign o_out.name_byte         = r_out.name_byte;
    assign o_out.compressed_size   = r_out.compressed_size;
    assign o_out.uncompressed_size = r_out.uncompressed_size;
    assign o_out.name_length       = r_out.name_length;
    assign o_out.entry_number      = r_out.entry_number;
    assign o_out.status            = r_out.status;
    assign o_out.final_res         = r_out.final_res;

    a_pend_has_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> r_out_valid)
        else $error("pending tail without a name item in the output register");

    a_pend_after_name: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_pend) |-> r_out.kind == zcd_pkg::KIND_NAME)
        else $error("split event did not start with its name item");

    a_error_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind == zcd_pkg::KIND_ERROR)
            |-> (r_out.final_res && r_out.status != zcd_pkg::ST_OK))
        else $error("error item without final flag or status");

endmodule

// File: rtl/core/zip_central_directory_parser.sv
// ============================================================================
// zip_central_directory_parser
// Parses ZIP central directory records from a byte stream and reports
// name bytes, per-entry sizes (with ZIP64 substitution) and errors.
// ============================================================================
// i_in  : one directory byte per item, end_of_data on the last byte available.
// i_cfg_we/i_cfg_data: number of records to parse; write it while idle.
// o_out : result items: name byte, entry complete or error; final_res is set
//         on the last entry and on any error.
// An accepted byte's event is queued, then loaded into the output register;
// a byte with a name byte and an entry result gives the name item first.
// Throughput is one byte per cycle while the queue has room; the output
// register passes one result item per cycle while the receiver is ready. A
// receiver stall fills the queue (FIFO_DEPTH entries), then input ready drops.
// Reset (synchronous, active low) clears the parser, the record count (nothing
// is parsed until it is written) and the queue. After the last record or an
// error, bytes are accepted and dropped until reset.
// ============================================================================
module zip_central_directory_parser #(
    parameter int FIFO_DEPTH = zcd_pkg::FIFO_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    zcd_in_if.sink      i_in,
    zcd_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data
);

    logic          w_push, w_pop, w_full, w_empty;
    zcd_pkg::t_evt w_evt, w_head;

    zcd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_evt      (w_evt)
    );

    zcd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_evt),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_data  (w_head)
    );

    zcd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule
